[hw/rtl/pcrv_pkg.sv]
// Shared types, codes and defaults for the point ROI / voxel filter.
package pcrv_pkg;

  localparam int GRID_X_DEF = 128;
  localparam int GRID_Y_DEF = 64;
  localparam int GRID_Z_DEF = 32;

  // voxel index width per axis, enough for the largest grid edge
  localparam int IDX_W    = 10;
  localparam int ROW_BITS = 64;
  localparam int ROW_SH   = 6;

  localparam logic [19:0] KEPT_MAX = 20'hFFFFF;

  localparam logic [1:0]  MODE_RST   = 2'd3;
  localparam logic [9:0]  STRIDE_RST = 10'd1;
  localparam logic [19:0] MAXP_RST   = 20'd30000;
  localparam logic [11:0] VSIZE_RST  = 12'd100;
  localparam logic [39:0] ROI_X_RST  = 40'd6292500576;
  localparam logic [39:0] ROI_Y_RST  = 40'd3146773576;
  localparam logic [39:0] ROI_Z_RST  = 40'd1888484776;

  localparam logic OP_FRAME = 1'b1;

  typedef enum logic [2:0] {
    REG_MODE   = 3'd0,
    REG_STRIDE = 3'd1,
    REG_MAXP   = 3'd2,
    REG_VSIZE  = 3'd3,
    REG_ROI_X  = 3'd4,
    REG_ROI_Y  = 3'd5,
    REG_ROI_Z  = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    R_KEPT    = 3'd0,
    R_STRIDE  = 3'd1,
    R_INVALID = 3'd2,
    R_OUTSIDE = 3'd3,
    R_DUP     = 3'd4,
    R_CAP     = 3'd5,
    R_FRAME   = 3'd6
  } reason_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_ADR,
    B_RD
  } back_state_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [9:0]  stride;
    logic [19:0] kept_cap;
    logic [11:0] vox_edge;
    logic [39:0] roi_x;
    logic [39:0] roi_y;
    logic [39:0] roi_z;
  } cfg_t;

  // classified point handed from front to back
  typedef struct packed {
    logic             op;
    logic             cv;
    logic             inbox;
    logic             voxel;
    logic [IDX_W-1:0] ix;
    logic [IDX_W-1:0] iy;
    logic [IDX_W-1:0] iz;
  } job_t;

endpackage

[hw/rtl/pcrv_ram.sv]
// Generic single-port RAM with registered read.
module pcrv_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                     wdata,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

[hw/rtl/pcrv_front.sv]
// Front end: box test and restoring voxel-index division, one quotient bit per cycle.
module pcrv_front
  import pcrv_pkg::*;
#(
  parameter int GRID_X = GRID_X_DEF,
  parameter int GRID_Y = GRID_Y_DEF,
  parameter int GRID_Z = GRID_Z_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               clearing,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               op,
  input  logic signed [19:0] x_mm,
  input  logic signed [19:0] y_mm,
  input  logic signed [19:0] z_mm,
  input  logic               coords_valid,
  input  logic               q_full,
  output logic               push,
  output job_t               job
);

  localparam logic [IDX_W:0] LIM_X = (IDX_W + 1)'(GRID_X);
  localparam logic [IDX_W:0] LIM_Y = (IDX_W + 1)'(GRID_Y);
  localparam logic [IDX_W:0] LIM_Z = (IDX_W + 1)'(GRID_Z);

  front_state_t fst, fst_next;

  logic             op_r, cv_r, inbox_r;
  logic             neg [3];
  logic [22:0]      rem [3];
  logic [IDX_W-1:0] quo [3];
  logic [3:0]       k;

  logic signed [19:0] crd [3];
  logic [39:0]        bnd [3];
  logic [22:0]        trial [3];
  logic [22:0]        dvs;
  logic [IDX_W:0]     lim [3];
  logic               ok [3];
  logic               accept, inb_all;
  logic               inb [3];
  logic signed [20:0] dif [3];

  assign crd[0] = x_mm;
  assign crd[1] = y_mm;
  assign crd[2] = z_mm;
  assign bnd[0] = cfg.roi_x;
  assign bnd[1] = cfg.roi_y;
  assign bnd[2] = cfg.roi_z;
  assign lim[0] = LIM_X;
  assign lim[1] = LIM_Y;
  assign lim[2] = LIM_Z;

  assign in_stall = (fst != F_IDLE) || clearing;
  assign accept   = in_valid && !in_stall;
  assign dvs      = 23'(cfg.vox_edge) << k;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      inb[a]   = (crd[a] >= $signed(bnd[a][19:0])) && (crd[a] <= $signed(bnd[a][39:20]));
      dif[a]   = 21'(crd[a]) - 21'($signed(bnd[a][19:0]));
      trial[a] = rem[a] - dvs;
      ok[a]    = !neg[a] && (rem[a] < 23'(cfg.vox_edge)) && ({1'b0, quo[a]} < lim[a]);
    end
    inb_all = inb[0] && inb[1] && inb[2];
  end

  always_comb begin
    fst_next = fst;
    push     = 1'b0;
    unique case (fst)
      F_IDLE: begin
        if (accept) fst_next = F_DIV;
      end
      F_DIV: begin
        if (k == 4'd0) fst_next = F_PUSH;
      end
      F_PUSH: begin
        if (!q_full) begin
          push     = 1'b1;
          fst_next = F_IDLE;
        end
      end
      default: fst_next = F_IDLE;
    endcase
  end

  always_comb begin
    job.op    = op_r;
    job.cv    = cv_r;
    job.inbox = inbox_r;
    job.voxel = cfg.mode[1] && (cfg.vox_edge != 12'd0) && ok[0] && ok[1] && ok[2];
    job.ix    = quo[0];
    job.iy    = quo[1];
    job.iz    = quo[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fst <= F_IDLE;
    end else begin
      fst <= fst_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fst == F_IDLE && accept) begin
      op_r    <= op;
      cv_r    <= coords_valid;
      inbox_r <= inb_all;
      k       <= 4'(IDX_W - 1);
      for (int a = 0; a < 3; a++) begin
        neg[a] <= dif[a][20];
        rem[a] <= {3'b000, dif[a][19:0]};
        quo[a] <= '0;
      end
    end else if (fst == F_DIV) begin
      for (int a = 0; a < 3; a++) begin
        if (!trial[a][22]) begin
          rem[a]    <= trial[a];
          quo[a][k] <= 1'b1;
        end
      end
      if (k != 4'd0) k <= k - 4'd1;
    end
  end

endmodule

[hw/rtl/pcrv_queue.sv]
// Two-entry queue of classified points between front and back.
module pcrv_queue
  import pcrv_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic avail,
  output job_t head
);

  job_t       slots [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign full  = (cnt == 2'd2);
  assign avail = (cnt != 2'd0);
  assign head  = slots[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wp] <= push_job;
  end

endmodule

[hw/rtl/pcrv_back.sv]
// Back end: stride, cap and counters, occupancy bitmap read-modify-write, result register.
module pcrv_back
  import pcrv_pkg::*;
#(
  parameter int GRID_X = GRID_X_DEF,
  parameter int GRID_Y = GRID_Y_DEF,
  parameter int GRID_Z = GRID_Z_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        job_avail,
  input  job_t        job,
  output logic        pop,
  output logic        clearing,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        keep,
  output logic [2:0]  reason,
  output logic [19:0] kept_count,
  output logic        cap_reached
);

  localparam int OCC  = GRID_X * GRID_Y * GRID_Z;
  localparam int AW0  = OCC > 1 ? $clog2(OCC) : 1;
  localparam int AW   = AW0 < ROW_SH + 1 ? ROW_SH + 1 : AW0;
  localparam int ROWS = (OCC + ROW_BITS - 1) / ROW_BITS;
  localparam int RAW  = ROWS > 1 ? $clog2(ROWS) : 1;
  localparam logic [RAW-1:0] LAST_ROW = RAW'(ROWS - 1);

  back_state_t bst, bst_next;

  logic [9:0]        seen;
  logic [19:0]       kept;
  logic              done;
  logic [RAW-1:0]    clr_row;
  logic [RAW-1:0]    row_r;
  logic [ROW_SH-1:0] bit_r;
  job_t              job_r;
  logic [AW-1:0]     tmp;
  reason_t           out_reason;

  logic [9:0]          st;
  logic [10:0]         nxt;
  logic [9:0]          seen_pt;
  logic                seen_upd;
  logic                ld, do_keep, do_frame;
  reason_t             ld_reason;
  logic [19:0]         kept_inc;
  logic                done_new;
  logic [AW-1:0]       vaddr;
  logic                ram_en, ram_we;
  logic [RAW-1:0]      ram_addr;
  logic [ROW_BITS-1:0] ram_wdata, ram_rdata;
  logic                hit;

  assign clearing = (bst == B_CLEAR);
  assign st       = (cfg.stride == 10'd0) ? 10'd1 : cfg.stride;
  assign nxt      = 11'(seen) + 11'd1;
  assign seen_pt  = (nxt >= 11'(st)) ? 10'd0 : nxt[9:0];
  assign kept_inc = (kept < KEPT_MAX) ? kept + 20'd1 : kept;
  assign done_new = done || ((cfg.kept_cap != 20'd0) && (kept_inc >= cfg.kept_cap));
  assign vaddr    = tmp * AW'(GRID_Z) + AW'(job_r.iz);
  assign hit      = ram_rdata[bit_r];

  assign keep   = (out_reason == R_KEPT);
  assign reason = out_reason;

  always_comb begin
    bst_next  = bst;
    pop       = 1'b0;
    ld        = 1'b0;
    ld_reason = R_KEPT;
    do_keep   = 1'b0;
    do_frame  = 1'b0;
    seen_upd  = 1'b0;
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = row_r;
    ram_wdata = ram_rdata | (ROW_BITS'(1) << bit_r);
    unique case (bst)
      B_CLEAR: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = clr_row;
        ram_wdata = '0;
        if (clr_row == LAST_ROW) bst_next = B_IDLE;
      end
      B_IDLE: begin
        if (job_avail && (!out_valid || !out_stall)) begin
          pop = 1'b1;
          if (job.op == OP_FRAME) begin
            ld        = 1'b1;
            ld_reason = R_FRAME;
            do_frame  = 1'b1;
            bst_next  = B_CLEAR;
          end else if (done) begin
            ld        = 1'b1;
            ld_reason = R_CAP;
          end else begin
            seen_upd = 1'b1;
            if (seen != 10'd0) begin
              ld        = 1'b1;
              ld_reason = R_STRIDE;
            end else if (!job.cv) begin
              ld        = 1'b1;
              ld_reason = R_INVALID;
            end else if (cfg.mode[0] && !job.inbox) begin
              ld        = 1'b1;
              ld_reason = R_OUTSIDE;
            end else if (job.voxel) begin
              bst_next = B_ADR;
            end else begin
              ld      = 1'b1;
              do_keep = 1'b1;
            end
          end
        end
      end
      B_ADR: begin
        // read the bitmap row; its data is back next cycle
        ram_en   = 1'b1;
        ram_addr = RAW'(vaddr >> ROW_SH);
        bst_next = B_RD;
      end
      B_RD: begin
        ld = 1'b1;
        if (hit) begin
          ld_reason = R_DUP;
        end else begin
          ram_en  = 1'b1;
          ram_we  = 1'b1;
          do_keep = 1'b1;
        end
        bst_next = B_IDLE;
      end
      default: bst_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bst       <= B_CLEAR;
      clr_row   <= '0;
      seen      <= '0;
      kept      <= '0;
      done      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      bst <= bst_next;
      if (bst == B_CLEAR) clr_row <= clr_row + RAW'(1);
      if (do_frame) begin
        clr_row <= '0;
        seen    <= '0;
        kept    <= '0;
        done    <= 1'b0;
      end
      if (seen_upd) seen <= seen_pt;
      if (do_keep) begin
        kept <= kept_inc;
        done <= done_new;
      end
      if (ld) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) job_r <= job;
    if (bst == B_IDLE) tmp <= AW'(job.ix) * AW'(GRID_Y) + AW'(job.iy);
    if (bst == B_ADR) begin
      row_r <= RAW'(vaddr >> ROW_SH);
      bit_r <= vaddr[ROW_SH-1:0];
    end
    if (ld) begin
      out_reason  <= ld_reason;
      kept_count  <= do_keep ? kept_inc : (do_frame ? 20'd0 : kept);
      cap_reached <= do_keep ? done_new : (do_frame ? 1'b0 : done);
    end
  end

  pcrv_ram #(
    .WIDTH(ROW_BITS),
    .DEPTH(ROWS)
  ) u_occ (
    .clk  (clk),
    .en   (ram_en),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  a_frame_clears: assert property (@(posedge clk) disable iff (rst)
    (ld && ld_reason == R_FRAME) |=> (kept_count == 20'd0) && !cap_reached && (kept == 20'd0))
    else $error("frame start left counters set");

  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    (bst == B_CLEAR) |-> !pop)
    else $error("job taken during bitmap clear");

  a_keep_counts: assert property (@(posedge clk) disable iff (rst)
    (ld && do_keep) |=> (kept == $past(kept) + 20'd1) || ($past(kept) == KEPT_MAX))
    else $error("kept point not counted");

  a_result_free: assert property (@(posedge clk) disable iff (rst)
    ld |-> (!out_valid || !out_stall) || (bst == B_RD))
    else $error("result register overwritten");

endmodule

[hw/rtl/pointcloud_roi_voxel_filter_top.sv]
// Top level of the lidar point ROI crop and voxel de-duplication filter.
//
//  channel | handshake             | payload
//  --------+-----------------------+-----------------------------------------
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//  in      | in_valid / in_stall   | op, x_mm, y_mm, z_mm, coords_valid
//  out     | out_valid / out_stall | keep, reason, kept_count, cap_reached
//
// Front: accept, then divide (one quotient bit per axis per cycle), then push, which waits while the queue is full.
// Back: a point is handled in B_IDLE, plus B_ADR and B_RD for the bitmap read-modify-write on the single RAM port.
// The front takes a new point only after it has pushed the previous one into the queue.
// After reset and after each frame start the bitmap clear writes ceil(GX*GY*GZ/64) rows
// (4096 by default) of zeros, and in_stall is high until it finishes.
// A two-entry queue and the result register let input and output stall independently.
module pointcloud_roi_voxel_filter_top
  import pcrv_pkg::*;
#(
  parameter int GRID_X = GRID_X_DEF,
  parameter int GRID_Y = GRID_Y_DEF,
  parameter int GRID_Z = GRID_Z_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [39:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               op,
  input  logic signed [19:0] x_mm,
  input  logic signed [19:0] y_mm,
  input  logic signed [19:0] z_mm,
  input  logic               coords_valid,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               keep,
  output logic [2:0]         reason,
  output logic [19:0]        kept_count,
  output logic               cap_reached
);

  cfg_t cfg;
  job_t f_job, q_head;
  logic push, q_full, q_avail, pop, clearing;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode     <= MODE_RST;
      cfg.stride   <= STRIDE_RST;
      cfg.kept_cap <= MAXP_RST;
      cfg.vox_edge <= VSIZE_RST;
      cfg.roi_x    <= ROI_X_RST;
      cfg.roi_y    <= ROI_Y_RST;
      cfg.roi_z    <= ROI_Z_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODE:   cfg.mode     <= cfg_data[1:0];
        REG_STRIDE: cfg.stride   <= cfg_data[9:0];
        REG_MAXP:   cfg.kept_cap <= cfg_data[19:0];
        REG_VSIZE:  cfg.vox_edge <= cfg_data[11:0];
        REG_ROI_X:  cfg.roi_x    <= cfg_data;
        REG_ROI_Y:  cfg.roi_y    <= cfg_data;
        REG_ROI_Z:  cfg.roi_z    <= cfg_data;
        default: ;
      endcase
    end
  end

  pcrv_front #(
    .GRID_X(GRID_X),
    .GRID_Y(GRID_Y),
    .GRID_Z(GRID_Z)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .clearing    (clearing),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .x_mm        (x_mm),
    .y_mm        (y_mm),
    .z_mm        (z_mm),
    .coords_valid(coords_valid),
    .q_full      (q_full),
    .push        (push),
    .job         (f_job)
  );

  pcrv_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(f_job),
    .full    (q_full),
    .pop     (pop),
    .avail   (q_avail),
    .head    (q_head)
  );

  pcrv_back #(
    .GRID_X(GRID_X),
    .GRID_Y(GRID_Y),
    .GRID_Z(GRID_Z)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .job_avail  (q_avail),
    .job        (q_head),
    .pop        (pop),
    .clearing   (clearing),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .keep       (keep),
    .reason     (reason),
    .kept_count (kept_count),
    .cap_reached(cap_reached)
  );

endmodule
